>>> design/fpr_pkg.sv
// Shared types, codes and the CRC-8 step for the framed packet receiver.
// No dependencies; used by fpr_parser and the top level.
package fpr_pkg;

  localparam int MAX_LEN_DEFAULT = 32;
  localparam int LEN_W = 6;

  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  // register indexes on the config port
  localparam logic [2:0] CFG_CRC_POLY  = 3'd0;
  localparam logic [2:0] CFG_CRC_INIT  = 3'd1;
  localparam logic [2:0] CFG_ACK_CODE  = 3'd2;
  localparam logic [2:0] CFG_NACK_CODE = 3'd3;
  localparam logic [2:0] CFG_ERR_CODE  = 3'd4;

  localparam logic [7:0] CRC_POLY_RST  = 8'h07;
  localparam logic [7:0] CRC_INIT_RST  = 8'h00;
  localparam logic [7:0] ACK_CODE_RST  = 8'h06;
  localparam logic [7:0] NACK_CODE_RST = 8'h15;
  localparam logic [7:0] ERR_CODE_RST  = 8'h01;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_REPLY   = 2'd2;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_ACK     = 2'd2;
  localparam logic [1:0] ST_NACK    = 2'd3;

  // parser -> emitter: frame complete pulse plus held header
  typedef struct packed {
    logic             done;
    logic             crc_ok;
    logic [7:0]       seq;
    logic [7:0]       cmd;
    logic [LEN_W-1:0] len;
  } frame_t;

  // MSB-first, non-reflected CRC-8 over one byte
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b,
                                             logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/fpr_parser.sv
// Frame parser: STX/LEN/SEQ/CMD/payload/CRC/ETX state machine, header
// registers, running CRC-8 and the payload memory. Depends on fpr_pkg.
module fpr_parser #(
  parameter int MAX_LEN = fpr_pkg::MAX_LEN_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_fire,
  input  logic [7:0]               rx_byte,
  input  logic [7:0]               crc_poly,
  input  logic [7:0]               crc_init,
  input  logic                     rd_en,
  input  logic [fpr_pkg::LEN_W-1:0] rd_addr,
  output logic [7:0]               rd_data,
  output fpr_pkg::frame_t          frame
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic [2:0] {
    P_WAIT, P_LEN, P_SEQ, P_CMD, P_PAY, P_CRC, P_ETX
  } pstate_t;

  pstate_t                   state;
  logic [fpr_pkg::LEN_W-1:0] held_len;
  logic [7:0]                held_seq;
  logic [7:0]                held_cmd;
  logic [fpr_pkg::LEN_W-1:0] payload_index;
  logic [fpr_pkg::LEN_W-1:0] payload_index_next;
  logic [7:0]                received_crc;
  logic [7:0]                running_crc;
  logic [7:0]                crc_next;
  logic                      mem_we;

  logic [7:0] mem [MAX_LEN];

  assign crc_next           = fpr_pkg::crc8_update(running_crc, rx_byte, crc_poly);
  assign payload_index_next = payload_index + 1'b1;
  assign mem_we = in_fire && (state == P_PAY) &&
                  (payload_index < fpr_pkg::LEN_W'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= P_WAIT;
      held_len      <= '0;
      held_seq      <= '0;
      held_cmd      <= '0;
      payload_index <= '0;
      received_crc  <= '0;
      running_crc   <= fpr_pkg::CRC_INIT_RST;
    end else if (in_fire) begin
      case (state)
        P_LEN: begin
          held_len    <= rx_byte[fpr_pkg::LEN_W-1:0];
          running_crc <= crc_next;
          state       <= (rx_byte > 8'(MAX_LEN)) ? P_WAIT : P_SEQ;
        end
        P_SEQ: begin
          held_seq    <= rx_byte;
          running_crc <= crc_next;
          state       <= P_CMD;
        end
        P_CMD: begin
          held_cmd    <= rx_byte;
          running_crc <= crc_next;
          state       <= (held_len == '0) ? P_CRC : P_PAY;
        end
        P_PAY: begin
          running_crc   <= crc_next;
          payload_index <= payload_index_next;
          if (payload_index_next >= held_len) state <= P_CRC;
        end
        P_CRC: begin
          received_crc <= rx_byte;
          state        <= P_ETX;
        end
        P_ETX: begin
          state <= P_WAIT;
        end
        default: begin
          if (rx_byte == fpr_pkg::STX_BYTE) begin
            state         <= P_LEN;
            payload_index <= '0;
            running_crc   <= crc_init;
          end else begin
            state <= P_WAIT;
          end
        end
      endcase
    end
  end

  // payload store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[payload_index[AW-1:0]] <= rx_byte;
    if (rd_en)  rd_data <= mem[rd_addr[AW-1:0]];
  end

  assign frame.done   = in_fire && (state == P_ETX) && (rx_byte == fpr_pkg::ETX_BYTE);
  assign frame.crc_ok = (running_crc == received_crc);
  assign frame.seq    = held_seq;
  assign frame.cmd    = held_cmd;
  assign frame.len    = held_len;

endmodule

>>> design/framed_packet_receiver_with_ack_core.sv
// Top level of the framed packet receiver: config registers, result
// sequencer and output register. Depends on fpr_pkg and fpr_parser.
//
// Usage
//  - Input channel (in_valid/in_ready, rx_byte): one received byte per word.
//    Frames are STX LEN SEQ CMD PAYLOAD CRC ETX; bytes outside a frame,
//    oversize LEN and a bad ETX byte are dropped without any result.
//  - Output channel (out_valid/out_ready): one result word per handshake,
//    kind/status/header/data_byte/last; last marks the end of a frame's run.
//  - Config port: cfg_wr_en/cfg_index/cfg_data, write only, while idle.
// Timing
//  - While parsing, one byte is taken every cycle.
//  - After a good ETX is taken, input is held off while the run is built:
//    the ETX moves the sequencer to E_STATUS, which loads the status word
//    once the output slot is free; each header and reply word has its own
//    state, each payload word a read and a load state, as reads are registered.
//  - Input is taken again as soon as the last word is loaded, even while
//    that word still waits on out_ready.
//  - A stalled receiver simply holds the output register; the sequencer
//    waits on it and nothing is dropped.
// Reset (rst, synchronous): parser waits for STX, registers go to their
// defaults, output register empties. The payload memory is not cleared.
module framed_packet_receiver_with_ack_core #(
  parameter int MAX_LEN = fpr_pkg::MAX_LEN_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                kind,
  output logic [1:0]                status,
  output logic [7:0]                frame_seq,
  output logic [7:0]                frame_cmd,
  output logic [fpr_pkg::LEN_W-1:0] frame_len,
  output logic [7:0]                data_byte,
  output logic                      last,
  input  logic                      cfg_wr_en,
  input  logic [2:0]                cfg_index,
  input  logic [7:0]                cfg_data
);

  typedef enum logic [3:0] {
    E_IDLE, E_STATUS, E_PRD, E_PDAT, E_STX, E_LEN, E_SEQ, E_CMD,
    E_ERR, E_CRC, E_ETX
  } estate_t;

  // config registers
  logic [7:0] crc_poly, crc_init, ack_code, nack_code, crc_error_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly       <= fpr_pkg::CRC_POLY_RST;
      crc_init       <= fpr_pkg::CRC_INIT_RST;
      ack_code       <= fpr_pkg::ACK_CODE_RST;
      nack_code      <= fpr_pkg::NACK_CODE_RST;
      crc_error_code <= fpr_pkg::ERR_CODE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fpr_pkg::CFG_CRC_POLY:  crc_poly       <= cfg_data;
        fpr_pkg::CFG_CRC_INIT:  crc_init       <= cfg_data;
        fpr_pkg::CFG_ACK_CODE:  ack_code       <= cfg_data;
        fpr_pkg::CFG_NACK_CODE: nack_code      <= cfg_data;
        fpr_pkg::CFG_ERR_CODE:  crc_error_code <= cfg_data;
        default: ;
      endcase
    end
  end

  estate_t                   estate, estate_next;
  logic                      in_fire;
  fpr_pkg::frame_t           frame;
  logic                      rd_en;
  logic [7:0]                rd_data;
  logic [fpr_pkg::LEN_W-1:0] idx, idx_next;
  logic [7:0]                rcrc, rcrc_next;
  logic [1:0]                run_status, start_status;
  logic                      slot_free;
  logic                      is_err;
  logic                      load;
  logic [1:0]                load_kind;
  logic [7:0]                load_data;
  logic                      load_last;
  logic [7:0]                reply_cmd;
  logic [7:0]                reply_len;

  // parser runs only while the sequencer is idle, so the payload memory
  // and header never change under a run
  assign in_ready = (estate == E_IDLE);
  assign in_fire  = in_valid && in_ready;

  fpr_parser #(.MAX_LEN(MAX_LEN)) u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .rx_byte  (rx_byte),
    .crc_poly (crc_poly),
    .crc_init (crc_init),
    .rd_en    (rd_en),
    .rd_addr  (idx),
    .rd_data  (rd_data),
    .frame    (frame)
  );

  // status decided at ETX; equal ack and nack codes count as ack
  always_comb begin
    if (!frame.crc_ok)              start_status = fpr_pkg::ST_CRC_ERR;
    else if (frame.cmd == ack_code)  start_status = fpr_pkg::ST_ACK;
    else if (frame.cmd == nack_code) start_status = fpr_pkg::ST_NACK;
    else                             start_status = fpr_pkg::ST_GOOD;
  end

  assign slot_free = !out_valid || out_ready;
  assign is_err    = (run_status == fpr_pkg::ST_CRC_ERR);
  assign reply_cmd = is_err ? nack_code : ack_code;
  assign reply_len = {7'd0, is_err};

  always_comb begin
    estate_next = estate;
    idx_next    = idx;
    rcrc_next   = rcrc;
    rd_en       = 1'b0;
    load        = 1'b0;
    load_kind   = fpr_pkg::KIND_REPLY;
    load_data   = '0;
    load_last   = 1'b0;
    case (estate)
      E_IDLE: begin
        if (frame.done) estate_next = E_STATUS;
      end
      E_STATUS: begin
        if (slot_free) begin
          load      = 1'b1;
          load_kind = fpr_pkg::KIND_STATUS;
          if (run_status == fpr_pkg::ST_ACK || run_status == fpr_pkg::ST_NACK) begin
            load_last   = 1'b1;
            estate_next = E_IDLE;
          end else if (is_err || frame.len == '0) begin
            estate_next = E_STX;
          end else begin
            idx_next    = '0;
            estate_next = E_PRD;
          end
        end
      end
      E_PRD: begin
        rd_en       = 1'b1;
        estate_next = E_PDAT;
      end
      E_PDAT: begin
        // rd_data holds until the next read, so a stall here is safe
        if (slot_free) begin
          load        = 1'b1;
          load_kind   = fpr_pkg::KIND_PAYLOAD;
          load_data   = rd_data;
          idx_next    = idx + 1'b1;
          estate_next = (idx_next == frame.len) ? E_STX : E_PRD;
        end
      end
      E_STX: begin
        if (slot_free) begin
          load        = 1'b1;
          load_data   = fpr_pkg::STX_BYTE;
          rcrc_next   = crc_init;
          estate_next = E_LEN;
        end
      end
      E_LEN: begin
        if (slot_free) begin
          load        = 1'b1;
          load_data   = reply_len;
          rcrc_next   = fpr_pkg::crc8_update(rcrc, reply_len, crc_poly);
          estate_next = E_SEQ;
        end
      end
      E_SEQ: begin
        if (slot_free) begin
          load        = 1'b1;
          load_data   = frame.seq;
          rcrc_next   = fpr_pkg::crc8_update(rcrc, frame.seq, crc_poly);
          estate_next = E_CMD;
        end
      end
      E_CMD: begin
        if (slot_free) begin
          load        = 1'b1;
          load_data   = reply_cmd;
          rcrc_next   = fpr_pkg::crc8_update(rcrc, reply_cmd, crc_poly);
          estate_next = is_err ? E_ERR : E_CRC;
        end
      end
      E_ERR: begin
        if (slot_free) begin
          load        = 1'b1;
          load_data   = crc_error_code;
          rcrc_next   = fpr_pkg::crc8_update(rcrc, crc_error_code, crc_poly);
          estate_next = E_CRC;
        end
      end
      E_CRC: begin
        if (slot_free) begin
          load        = 1'b1;
          load_data   = rcrc;
          estate_next = E_ETX;
        end
      end
      E_ETX: begin
        if (slot_free) begin
          load        = 1'b1;
          load_data   = fpr_pkg::ETX_BYTE;
          load_last   = 1'b1;
          estate_next = E_IDLE;
        end
      end
      default: estate_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      estate    <= E_IDLE;
      out_valid <= 1'b0;
    end else begin
      estate <= estate_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    idx  <= idx_next;
    rcrc <= rcrc_next;
    if (estate == E_IDLE && frame.done) run_status <= start_status;
    if (load) begin
      kind      <= load_kind;
      status    <= run_status;
      frame_seq <= frame.seq;
      frame_cmd <= frame.cmd;
      frame_len <= frame.len;
      data_byte <= load_data;
      last      <= load_last;
    end
  end

endmodule

>>> design/fpr_checker.sv
// Port-level checks for the framed packet receiver, bound to the top level.
// Depends on fpr_pkg and framed_packet_receiver_with_ack_core.
module fpr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                kind,
  input logic [1:0]                status,
  input logic [7:0]                data_byte,
  input logic                      last
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(last))
    else $error("output word changed while stalled");

  // no byte is taken in the middle of a result run
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken during result run");

  a_status_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == fpr_pkg::KIND_STATUS |-> data_byte == 8'd0)
    else $error("status word with nonzero data");

  a_ack_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == fpr_pkg::KIND_STATUS &&
    (status == fpr_pkg::ST_ACK || status == fpr_pkg::ST_NACK) |-> last)
    else $error("ack/nack status not alone");

  a_reply_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && kind == fpr_pkg::KIND_REPLY |-> data_byte == fpr_pkg::ETX_BYTE)
    else $error("reply run does not end on ETX");

endmodule

bind framed_packet_receiver_with_ack_core fpr_checker u_fpr_checker (.*);

>>> sim/tb_framed_packet_receiver_with_ack_core.sv
// Self-checking testbench for framed_packet_receiver_with_ack_core: byte stream in,
// status/payload/reply words out, checked against an in-bench frame predictor.
// Depends on fpr_pkg and the receiver RTL only.
module tb_framed_packet_receiver_with_ack_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fpr_pkg::*;

  localparam int MAX_LEN     = MAX_LEN_DEFAULT;
  localparam int PHASE_BYTES = 48;    // random bytes per register setting
  localparam int SETTLE      = 8;     // quiet cycles before a register write
  localparam int TAIL        = 20;    // quiet cycles after the last word
  localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
  localparam int NUM_SETS    = 6;

  // parser position, mirrors the frame layout
  typedef enum logic [2:0] {
    P_WAIT, P_LEN, P_SEQ, P_CMD, P_PAY, P_CRC, P_ETX
  } parse_t;

  // one output word as seen on the result channel
  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [7:0]       seq;
    logic [7:0]       cmd;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
    logic             last;
  } word_t;

  typedef struct packed {
    logic [7:0] poly;
    logic [7:0] init;
    logic [7:0] ack;
    logic [7:0] nack;
    logic [7:0] err;
  } reg_set_t;

  // opening script: a byte, or a CRC byte filled in from the running CRC
  typedef enum logic [1:0] {R_BYTE, R_GOOD_CRC, R_BAD_CRC} row_kind_t;
  // typed expectation for a script row
  typedef enum logic [1:0] {C_NONE, C_QUIET, C_STATUS} chk_t;

  typedef struct packed {
    row_kind_t  what;
    logic [7:0] b;
    chk_t       chk;
    logic [1:0] st;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           kind;
  logic [1:0]           status;
  logic [7:0]           frame_seq;
  logic [7:0]           frame_cmd;
  logic [LEN_W-1:0]     frame_len;
  logic [7:0]           data_byte;
  logic                 last;
  logic                 cfg_wr_en;
  logic [2:0]           cfg_index;
  logic [7:0]           cfg_data;

  framed_packet_receiver_with_ack_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .status    (status),
    .frame_seq (frame_seq),
    .frame_cmd (frame_cmd),
    .frame_len (frame_len),
    .data_byte (data_byte),
    .last      (last),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Frame predictor state. Updated only in the posedge monitor below;
  // the stimulus side reads it at falling edges.
  // ---------------------------------------------------------------------
  logic [7:0] cfg_poly, cfg_init, cfg_ack, cfg_nack, cfg_err;
  parse_t     pstate;
  logic [7:0] len_q, seq_q, cmd_q;
  logic [5:0] pay_idx;
  logic [7:0] rcv_crc;
  logic [7:0] run_crc;
  logic [7:0] pay_store [MAX_LEN];

  word_t pending_words[$];   // words the receiver still owes us

  int errors;
  int rx_accepts;            // bytes taken by the receiver
  int words_checked;
  int stall_cycles;
  int step_words;            // words caused by the last accepted byte
  logic [1:0] step_status;   // status of that run
  int frames_by_status [4];
  int payload_words, reply_words;
  int bytes_sent;
  int burst_left;

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= 25) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // MSB-first CRC-8 under the current polynomial
  function automatic logic [7:0] crc8_step(input logic [7:0] c_in, input logic [7:0] b);
    logic [7:0] c;
    c = c_in ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ cfg_poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic void push_word(input logic [1:0] k, input logic [1:0] st,
                                    input logic [7:0] d);
    word_t w;
    w = '{kind: k, status: st, seq: seq_q, cmd: cmd_q, len: len_q[LEN_W-1:0],
          data: d, last: 1'b0};
    pending_words.push_back(w);
    if (k == KIND_PAYLOAD) payload_words++;
    if (k == KIND_REPLY) reply_words++;
  endfunction

  // reply frame: STX LEN SEQ CMD [byte] CRC ETX, echoing the received SEQ
  function automatic void push_reply(input logic [1:0] st, input logic [7:0] rcmd,
                                     input logic has_pay, input logic [7:0] pbyte);
    logic [7:0] c;
    logic [7:0] plen;
    plen = has_pay ? 8'd1 : 8'd0;
    c = crc8_step(cfg_init, plen);
    c = crc8_step(c, seq_q);
    c = crc8_step(c, rcmd);
    push_word(KIND_REPLY, st, STX_BYTE);
    push_word(KIND_REPLY, st, plen);
    push_word(KIND_REPLY, st, seq_q);
    push_word(KIND_REPLY, st, rcmd);
    if (has_pay) begin
      c = crc8_step(c, pbyte);
      push_word(KIND_REPLY, st, pbyte);
    end
    push_word(KIND_REPLY, st, c);
    push_word(KIND_REPLY, st, ETX_BYTE);
  endfunction

  // advance the parser by one received byte and queue the words it causes
  function automatic void rx_parse_byte(input logic [7:0] b);
    int n0;
    logic [1:0] st;
    n0 = pending_words.size();
    case (pstate)
      P_LEN: begin
        len_q   = b;
        run_crc = crc8_step(run_crc, b);
        pstate  = (b > MAX_LEN) ? P_WAIT : P_SEQ;   // oversize LEN drops the frame
      end
      P_SEQ: begin
        seq_q   = b;
        run_crc = crc8_step(run_crc, b);
        pstate  = P_CMD;
      end
      P_CMD: begin
        cmd_q   = b;
        run_crc = crc8_step(run_crc, b);
        pstate  = (len_q == 0) ? P_CRC : P_PAY;
      end
      P_PAY: begin
        if (pay_idx < MAX_LEN) pay_store[pay_idx] = b;
        run_crc = crc8_step(run_crc, b);
        pay_idx = pay_idx + 6'd1;
        if (pay_idx >= len_q) pstate = P_CRC;
      end
      P_CRC: begin
        rcv_crc = b;
        pstate  = P_ETX;
      end
      P_ETX: begin
        pstate = P_WAIT;
        // anything but ETX here is dropped silently
        if (b == ETX_BYTE) begin
          if (run_crc != rcv_crc) begin
            st = ST_CRC_ERR;
            push_word(KIND_STATUS, st, 8'h00);
            push_reply(st, cfg_nack, 1'b1, cfg_err);
          end else if (cmd_q == cfg_ack || cmd_q == cfg_nack) begin
            // equal codes count as ack
            st = (cmd_q == cfg_ack) ? ST_ACK : ST_NACK;
            push_word(KIND_STATUS, st, 8'h00);
          end else begin
            st = ST_GOOD;
            push_word(KIND_STATUS, st, 8'h00);
            for (int i = 0; i < len_q && i < MAX_LEN; i++) begin
              push_word(KIND_PAYLOAD, st, pay_store[i]);
            end
            push_reply(st, cfg_ack, 1'b0, 8'h00);
          end
          pending_words[pending_words.size()-1].last = 1'b1;
          step_status = st;
          frames_by_status[st]++;
        end
      end
      default: begin
        pstate = P_WAIT;
        if (b == STX_BYTE) begin
          pstate  = P_LEN;
          pay_idx = '0;
          run_crc = cfg_init;
        end
      end
    endcase
    step_words = pending_words.size() - n0;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: all sampling happens here, at the rising edge. Output words
  // are checked before the byte taken at the same edge is predicted, since
  // a word can never come from a byte taken in the same cycle.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    word_t got, want;
    logic moved;
    moved = 1'b0;
    if (rst) begin
      cfg_poly = CRC_POLY_RST;
      cfg_init = CRC_INIT_RST;
      cfg_ack  = ACK_CODE_RST;
      cfg_nack = NACK_CODE_RST;
      cfg_err  = ERR_CODE_RST;
      pstate   = P_WAIT;
      len_q    = '0;
      seq_q    = '0;
      cmd_q    = '0;
      pay_idx  = '0;
      rcv_crc  = '0;
      run_crc  = CRC_INIT_RST;
      foreach (pay_store[i]) pay_store[i] = '0;
      pending_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        moved = 1'b1;
        words_checked++;
        got = '{kind: kind, status: status, seq: frame_seq, cmd: frame_cmd,
                len: frame_len, data: data_byte, last: last};
        if (pending_words.size() == 0) begin
          note_mismatch($sformatf("unexpected word kind=%0d data=%02h", kind, data_byte));
        end else begin
          want = pending_words.pop_front();
          if (got.kind !== want.kind)
            note_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
          if (got.status !== want.status)
            note_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.seq !== want.seq)
            note_mismatch($sformatf("frame_seq %02h, want %02h", got.seq, want.seq));
          if (got.cmd !== want.cmd)
            note_mismatch($sformatf("frame_cmd %02h, want %02h", got.cmd, want.cmd));
          if (got.len !== want.len)
            note_mismatch($sformatf("frame_len %0d, want %0d", got.len, want.len));
          if (got.data !== want.data)
            note_mismatch($sformatf("data_byte %02h, want %02h (kind %0d)",
                                    got.data, want.data, want.kind));
          if (got.last !== want.last)
            note_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CRC_POLY:  cfg_poly = cfg_data;
          CFG_CRC_INIT:  cfg_init = cfg_data;
          CFG_ACK_CODE:  cfg_ack  = cfg_data;
          CFG_NACK_CODE: cfg_nack = cfg_data;
          CFG_ERR_CODE:  cfg_err  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        rx_parse_byte(rx_byte);
        rx_accepts++;
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
  end

  // Result side back-pressure: the mode is redrawn whenever its tick counter runs
  // out, from always-ready through random and sparse to long stalls.
  int       ready_ticks;
  int       ready_mode;
  always @(negedge clk) begin
    if (ready_ticks == 0) begin
      ready_mode  <= $urandom_range(0, 3);
      ready_ticks <= $urandom_range(16, 96);
    end else begin
      ready_ticks <= ready_ticks - 1;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (ready_ticks[1:0] == 2'd0);
      default: out_ready <= (ready_ticks[3:0] == 4'd0);
    endcase
  end

  // ---------------------------------------------------------------------
  // Sender side. Every task is entered and left at a falling edge.
  // ---------------------------------------------------------------------

  // Put one byte on the input channel and hold it until taken. The sender
  // runs in bursts; at the end of a burst valid drops for a random gap.
  task automatic send_byte(input logic [7:0] b);
    int n;
    int pick;
    n = rx_accepts;
    in_valid <= 1'b1;
    rx_byte  <= b;
    wait (rx_accepts != n);
    @(negedge clk);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 80) repeat ($urandom_range(1, 4)) @(negedge clk);
      else if (pick < 95) repeat ($urandom_range(5, 12)) @(negedge clk);
      else repeat ($urandom_range(20, 30)) @(negedge clk);
      // some bursts are long enough to run whole frames back to back
      burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(40, 80)
                                              : $urandom_range(1, 12);
    end
  endtask

  // Hold input until every predicted word is out, then let the block settle.
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Mixed byte source: leans on 00/FF and the framing bytes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return ($urandom_range(0, 1) != 0) ? STX_BYTE : ETX_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic program_regs(input reg_set_t s);
    write_reg(CFG_CRC_POLY,  s.poly);
    write_reg(CFG_CRC_INIT,  s.init);
    write_reg(CFG_ACK_CODE,  s.ack);
    write_reg(CFG_NACK_CODE, s.nack);
    write_reg(CFG_ERR_CODE,  s.err);
    cfg_wr_en <= 1'b0;
  endtask

  // One random frame. Mostly well formed with random content; some with a
  // bad CRC, a wrong closing byte, or an oversize LEN.
  task automatic drive_random_frame();
    int         pick;
    int         n;
    logic [7:0] lenb, cmd, crc, tail;
    pick = $urandom_range(0, 99);
    if (pick < 55)      n = $urandom_range(0, 4);
    else if (pick < 80) n = $urandom_range(5, 16);
    else if (pick < 88) n = $urandom_range(17, MAX_LEN - 1);
    else if (pick < 94) n = MAX_LEN;
    else                n = -1;
    send_byte(STX_BYTE);
    if (n < 0) begin
      // oversize: first illegal value, 6-bit wrap points, or anything above
      case ($urandom_range(0, 3))
        0:       lenb = 8'(MAX_LEN + 1);
        1:       lenb = 8'd64;
        2:       lenb = 8'hFF;
        default: lenb = 8'($urandom_range(MAX_LEN + 1, 255));
      endcase
      send_byte(lenb);
      return;
    end
    send_byte(8'(n));
    send_byte(pick_byte());
    pick = $urandom_range(0, 9);
    if (pick < 3)      cmd = cfg_ack;
    else if (pick < 5) cmd = cfg_nack;
    else               cmd = pick_byte();
    send_byte(cmd);
    for (int i = 0; i < n; i++) send_byte(pick_byte());
    // run_crc already holds the CRC over LEN..payload
    crc = run_crc;
    if ($urandom_range(0, 99) < 15) crc = crc ^ (8'h01 << $urandom_range(0, 7));
    send_byte(crc);
    tail = ETX_BYTE;
    if ($urandom_range(0, 9) == 0) begin
      tail = 8'($urandom);
      if (tail == ETX_BYTE) tail = ~tail;
    end
    send_byte(tail);
  endtask

  // Random stream for one register setting, then bring the parser back to
  // waiting for STX so the next register write lands between frames.
  task automatic random_phase();
    int target;
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) begin
      drive_random_frame();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(pick_byte());
      end
      // now and then let the whole backlog drain before going on
      if ($urandom_range(0, 19) == 0) wait_idle(0);
    end
    while (pstate != P_WAIT) send_byte(ETX_BYTE);
  endtask

  // Opening script under reset settings: an empty data frame with SEQ at
  // its top value, an ACK frame, a bad CRC on a NACK-coded frame (CRC error
  // wins), an oversize LEN followed by a stray byte, and a frame whose
  // closing byte is a start byte.
  row_t opening_bytes [0:26] = '{
    '{R_BYTE,     STX_BYTE,      C_NONE,   ST_GOOD},
    '{R_BYTE,     8'h00,         C_NONE,   ST_GOOD},
    '{R_BYTE,     8'hFF,         C_NONE,   ST_GOOD},
    '{R_BYTE,     8'h00,         C_NONE,   ST_GOOD},
    '{R_GOOD_CRC, 8'h00,         C_NONE,   ST_GOOD},
    '{R_BYTE,     ETX_BYTE,      C_STATUS, ST_GOOD},
    '{R_BYTE,     STX_BYTE,      C_NONE,   ST_GOOD},
    '{R_BYTE,     8'h00,         C_NONE,   ST_GOOD},
    '{R_BYTE,     8'h00,         C_NONE,   ST_GOOD},
    '{R_BYTE,     ACK_CODE_RST,  C_NONE,   ST_GOOD},
    '{R_GOOD_CRC, 8'h00,         C_NONE,   ST_GOOD},
    '{R_BYTE,     ETX_BYTE,      C_STATUS, ST_ACK},
    '{R_BYTE,     STX_BYTE,      C_NONE,   ST_GOOD},
    '{R_BYTE,     8'h00,         C_NONE,   ST_GOOD},
    '{R_BYTE,     8'h80,         C_NONE,   ST_GOOD},
    '{R_BYTE,     NACK_CODE_RST, C_NONE,   ST_GOOD},
    '{R_BAD_CRC,  8'h00,         C_NONE,   ST_GOOD},
    '{R_BYTE,     ETX_BYTE,      C_STATUS, ST_CRC_ERR},
    '{R_BYTE,     STX_BYTE,      C_NONE,   ST_GOOD},
    '{R_BYTE,     8'hFF,         C_QUIET,  ST_GOOD},
    '{R_BYTE,     8'h55,         C_QUIET,  ST_GOOD},
    '{R_BYTE,     STX_BYTE,      C_NONE,   ST_GOOD},
    '{R_BYTE,     8'h00,         C_NONE,   ST_GOOD},
    '{R_BYTE,     8'h01,         C_NONE,   ST_GOOD},
    '{R_BYTE,     NACK_CODE_RST, C_NONE,   ST_GOOD},
    '{R_GOOD_CRC, 8'h00,         C_NONE,   ST_GOOD},
    '{R_BYTE,     STX_BYTE,      C_QUIET,  ST_GOOD}
  };

  // Register settings after the reset one: zero polynomial, all-ones,
  // equal ACK/NACK codes, a random set, and back to reset values.
  reg_set_t reg_sets [1:NUM_SETS-1];

  // Watchdog: too long with nothing moving on either channel.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("timeout: %0d cycles without a handshake", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [7:0] b;
    in_valid   = 1'b0;
    rx_byte    = 8'h00;
    out_ready  = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = CFG_CRC_POLY;
    cfg_data   = 8'h00;
    rst        = 1'b1;
    burst_left = 1;

    reg_sets[1] = '{poly: 8'h00, init: 8'h00, ack: 8'h00, nack: 8'hFF, err: 8'h00};
    reg_sets[2] = '{poly: 8'hFF, init: 8'hFF, ack: 8'hFF, nack: 8'h00, err: 8'hFF};
    reg_sets[3] = '{poly: 8'h31, init: 8'hA5, ack: 8'h2A, nack: 8'h2A, err: 8'h80};
    reg_sets[4] = '{poly: 8'($urandom), init: 8'($urandom), ack: 8'($urandom),
                    nack: 8'($urandom), err: 8'($urandom)};
    reg_sets[5] = '{poly: CRC_POLY_RST, init: CRC_INIT_RST, ack: ACK_CODE_RST,
                    nack: NACK_CODE_RST, err: ERR_CODE_RST};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed opening, reset register values
    foreach (opening_bytes[i]) begin
      case (opening_bytes[i].what)
        R_GOOD_CRC: b = run_crc;
        R_BAD_CRC:  b = run_crc ^ 8'h01;
        default:    b = opening_bytes[i].b;
      endcase
      send_byte(b);
      if (opening_bytes[i].chk == C_QUIET && step_words != 0)
        note_mismatch($sformatf("opening byte %0d should cause no word", i));
      if (opening_bytes[i].chk == C_STATUS &&
          (step_words == 0 || step_status != opening_bytes[i].st))
        note_mismatch($sformatf("opening byte %0d: status %0d, want %0d",
                                i, step_status, opening_bytes[i].st));
    end
    random_phase();

    for (int p = 1; p < NUM_SETS; p++) begin
      // registers only change with the block drained and quiet
      wait_idle(SETTLE);
      program_regs(reg_sets[p]);
      random_phase();
    end

    wait_idle(TAIL);
    if (pending_words.size() != 0)
      note_mismatch($sformatf("%0d words never arrived", pending_words.size()));

    $display("ran %0d bytes over %0d register settings; frames good %0d, crc error %0d,",
             bytes_sent, NUM_SETS, frames_by_status[ST_GOOD], frames_by_status[ST_CRC_ERR]);
    $display("ack %0d, nack %0d; %0d words checked (%0d payload, %0d reply)",
             frames_by_status[ST_ACK], frames_by_status[ST_NACK], words_checked,
             payload_words, reply_words);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
design/fpr_pkg.sv
design/fpr_parser.sv
design/framed_packet_receiver_with_ack_core.sv
design/fpr_checker.sv
sim/tb_framed_packet_receiver_with_ack_core.sv
